@@ hdl/ir_pulse_command_decoder_defines.svh @@
// assertion macros used by the port-level checker of the ir pulse command decoder
`ifndef IR_PULSE_COMMAND_DECODER_DEFINES_SVH
`define IR_PULSE_COMMAND_DECODER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define IRPCD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define IRPCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/irpcd_pkg.sv @@
// types, constants and register indexes of the ir pulse command decoder
package irpcd_pkg;

    // default sizes
    localparam int DATA_BITS_DEF   = 8;
    localparam int COUNT_WIDTH_DEF = 16;

    // register field widths
    localparam int CFG_WIDTH   = 16;
    localparam int INDEX_WIDTH = 8;

    // register indexes
    typedef enum logic [INDEX_WIDTH-1:0] {
        CFG_FIRST_TIMEOUT    = 8'd0,
        CFG_BIT_TIMEOUT      = 8'd1,
        CFG_ZERO_LOW         = 8'd2,
        CFG_ZERO_HIGH        = 8'd3,
        CFG_ONE_LOW          = 8'd4,
        CFG_ONE_HIGH         = 8'd5,
        CFG_FIRST_DATA_INDEX = 8'd6
    } t_cfg_reg;

    // register reset values
    localparam logic [CFG_WIDTH-1:0]   RST_FIRST_TIMEOUT    = 16'd15000;
    localparam logic [CFG_WIDTH-1:0]   RST_BIT_TIMEOUT      = 16'd4000;
    localparam logic [CFG_WIDTH-1:0]   RST_ZERO_LOW         = 16'd1000;
    localparam logic [CFG_WIDTH-1:0]   RST_ZERO_HIGH        = 16'd1250;
    localparam logic [CFG_WIDTH-1:0]   RST_ONE_LOW          = 16'd2000;
    localparam logic [CFG_WIDTH-1:0]   RST_ONE_HIGH         = 16'd2400;
    localparam logic [INDEX_WIDTH-1:0] RST_FIRST_DATA_INDEX = 8'd17;

    // bit classification windows
    typedef struct packed {
        logic [CFG_WIDTH-1:0] zero_low;
        logic [CFG_WIDTH-1:0] zero_high;
        logic [CFG_WIDTH-1:0] one_low;
        logic [CFG_WIDTH-1:0] one_high;
    } t_windows;

endpackage

@@ hdl/ir_pulse_command_decoder.sv @@
// top level of the ir pulse command decoder
//
// Input channel: one beat per timer tick, i_falling_edge set when the ir line
// fell during that tick. A beat is taken when i_in_valid is high and o_in_stall
// is low. An edge while idle opens a frame; later edges record half the ticks
// since the previous edge. When the armed timeout passes without an edge the
// kept intervals are classified and one result beat carries o_command_byte and
// o_edges_counted, then the decoder goes idle.
// Output channel: a beat is taken when o_out_valid is high and i_out_stall low.
// Configuration: i_cfg_valid/o_cfg_ready with a register index and data; ready
// is always high, unknown indexes are dropped. Write only while idle.
// Pipeline: a tick beat goes into an input register and is worked from there;
// a resulting beat is loaded into the output register when its tick is worked.
// Throughput is one tick per cycle while o_in_stall is low, set by the state
// update between the two registers.
// Stall: with a result held on a stalled output, ticks that yield no result
// still flow; a tick that would yield a result waits, and o_in_stall rises.
// Reset (synchronous, active low) clears frame state, the interval store and
// the registers to their default values; no clearing pass is needed.
module ir_pulse_command_decoder #(
    parameter int DATA_BITS   = irpcd_pkg::DATA_BITS_DEF,
    parameter int COUNT_WIDTH = irpcd_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // tick channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_falling_edge,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [7:0]                          o_command_byte,
    output logic [7:0]                          o_edges_counted,
    // configuration channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [irpcd_pkg::INDEX_WIDTH-1:0]   i_cfg_index,
    input  logic [irpcd_pkg::CFG_WIDTH-1:0]     i_cfg_data
);

    localparam int CmpW   = (COUNT_WIDTH > irpcd_pkg::CFG_WIDTH) ?
                            COUNT_WIDTH : irpcd_pkg::CFG_WIDTH;
    localparam int IdxW   = (DATA_BITS > 1) ? $clog2(DATA_BITS) : 1;
    localparam int StoreW = COUNT_WIDTH - 1;

    // configuration registers
    logic [irpcd_pkg::CFG_WIDTH-1:0]   r_first_timeout;
    logic [irpcd_pkg::CFG_WIDTH-1:0]   r_bit_timeout;
    irpcd_pkg::t_windows               r_windows;
    logic [irpcd_pkg::INDEX_WIDTH-1:0] r_first_data_index;

    // input register
    logic r_in_valid;
    logic r_in_edge;

    // frame state
    logic                   r_frame_active;
    logic [7:0]             r_edge_index;
    logic [COUNT_WIDTH-1:0] r_tick;
    logic                   r_use_bit;
    logic [StoreW-1:0]      r_store [DATA_BITS];
    logic [DATA_BITS-1:0]   r_decoded;

    // output register
    logic       r_out_valid;
    logic [7:0] r_out_cmd;
    logic [7:0] r_out_edges;

    logic                            w_in_accept;
    logic [COUNT_WIDTH-1:0]          w_tick_inc;
    logic [irpcd_pkg::CFG_WIDTH-1:0] w_timeout;
    logic                            w_timed_out;
    logic                            w_emit;
    logic                            w_slot_free;
    logic                            w_advance;
    logic [7:0]                      w_offset;
    logic                            w_in_window;
    logic [IdxW-1:0]                 w_store_idx;
    logic [DATA_BITS-1:0]            w_decoded_next;
    logic [31:0]                     w_dec_ext;

    // configuration port
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_timeout    <= irpcd_pkg::RST_FIRST_TIMEOUT;
            r_bit_timeout      <= irpcd_pkg::RST_BIT_TIMEOUT;
            r_windows.zero_low  <= irpcd_pkg::RST_ZERO_LOW;
            r_windows.zero_high <= irpcd_pkg::RST_ZERO_HIGH;
            r_windows.one_low   <= irpcd_pkg::RST_ONE_LOW;
            r_windows.one_high  <= irpcd_pkg::RST_ONE_HIGH;
            r_first_data_index <= irpcd_pkg::RST_FIRST_DATA_INDEX;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                irpcd_pkg::CFG_FIRST_TIMEOUT:    r_first_timeout     <= i_cfg_data;
                irpcd_pkg::CFG_BIT_TIMEOUT:      r_bit_timeout       <= i_cfg_data;
                irpcd_pkg::CFG_ZERO_LOW:         r_windows.zero_low  <= i_cfg_data;
                irpcd_pkg::CFG_ZERO_HIGH:        r_windows.zero_high <= i_cfg_data;
                irpcd_pkg::CFG_ONE_LOW:          r_windows.one_low   <= i_cfg_data;
                irpcd_pkg::CFG_ONE_HIGH:         r_windows.one_high  <= i_cfg_data;
                irpcd_pkg::CFG_FIRST_DATA_INDEX: begin
                    r_first_data_index <= i_cfg_data[irpcd_pkg::INDEX_WIDTH-1:0];
                end
                default: ;
            endcase
        end
    end

    // input handshake and pipeline control
    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign w_advance   = r_in_valid && (!w_emit || w_slot_free);
    assign o_in_stall  = r_in_valid && !w_advance;
    assign w_in_accept = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_edge <= i_falling_edge;
        end
    end

    // saturating tick count and timeout check
    assign w_tick_inc  = (r_tick != {COUNT_WIDTH{1'b1}}) ? r_tick + 1'b1 : r_tick;
    assign w_timeout   = r_use_bit ? r_bit_timeout : r_first_timeout;
    assign w_timed_out = CmpW'(w_tick_inc) >= CmpW'(w_timeout);
    assign w_emit      = r_in_valid && r_frame_active && !r_in_edge && w_timed_out;

    // store slot for the current edge index
    assign w_offset    = r_edge_index - r_first_data_index;
    assign w_in_window = (r_edge_index >= r_first_data_index) &&
                         ({1'b0, w_offset} < 9'(DATA_BITS));
    assign w_store_idx = w_offset[IdxW-1:0];

    // bit classification
    irpcd_decode #(
        .DATA_BITS   (DATA_BITS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_decode (
        .i_intervals (r_store),
        .i_windows   (r_windows),
        .i_decoded   (r_decoded),
        .o_decoded   (w_decoded_next)
    );

    assign w_dec_ext = 32'(w_decoded_next);

    // frame state update, one tick per cycle while w_advance is high
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_active <= 1'b0;
            r_edge_index   <= '0;
            r_tick         <= '0;
            r_use_bit      <= 1'b0;
            r_decoded      <= '0;
            for (int k = 0; k < DATA_BITS; k++) begin
                r_store[k] <= '0;
            end
        end else if (w_advance) begin
            if (!r_frame_active) begin
                if (r_in_edge) begin
                    r_frame_active <= 1'b1;
                    r_edge_index   <= '0;
                    r_tick         <= '0;
                    r_use_bit      <= 1'b0;
                end
            end else if (r_in_edge) begin
                if (w_in_window) begin
                    r_store[w_store_idx] <= w_tick_inc[COUNT_WIDTH-1:1];
                end
                if (r_edge_index != 8'hFF) begin
                    r_edge_index <= r_edge_index + 8'd1;
                end
                r_tick    <= '0;
                r_use_bit <= 1'b1;
            end else if (w_timed_out) begin
                r_decoded      <= w_decoded_next;
                r_frame_active <= 1'b0;
                r_edge_index   <= '0;
                r_tick         <= '0;
                r_use_bit      <= 1'b0;
            end else begin
                r_tick <= w_tick_inc;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_emit) begin
            r_out_cmd   <= w_dec_ext[7:0];
            r_out_edges <= r_edge_index;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_command_byte  = r_out_cmd;
    assign o_edges_counted = r_out_edges;

endmodule

@@ hdl/irpcd_decode.sv @@
// classifies the kept pulse intervals into command bits
module irpcd_decode #(
    parameter int DATA_BITS   = irpcd_pkg::DATA_BITS_DEF,
    parameter int COUNT_WIDTH = irpcd_pkg::COUNT_WIDTH_DEF
) (
    input  logic [COUNT_WIDTH-2:0] i_intervals [DATA_BITS],
    input  irpcd_pkg::t_windows    i_windows,
    input  logic [DATA_BITS-1:0]   i_decoded,
    output logic [DATA_BITS-1:0]   o_decoded
);

    localparam int CmpW = (COUNT_WIDTH > irpcd_pkg::CFG_WIDTH) ?
                          COUNT_WIDTH : irpcd_pkg::CFG_WIDTH;

    // one independent classifier per bit, zero window checked first
    for (genvar g = 0; g < DATA_BITS; g++) begin : g_bit
        logic [CmpW-1:0] w_val;
        logic            w_is_zero;
        logic            w_is_one;

        assign w_val     = CmpW'(i_intervals[g]);
        assign w_is_zero = (w_val >= CmpW'(i_windows.zero_low)) &&
                           (w_val <= CmpW'(i_windows.zero_high));
        assign w_is_one  = (w_val >= CmpW'(i_windows.one_low)) &&
                           (w_val <= CmpW'(i_windows.one_high));

        always_comb begin
            if (w_is_zero) begin
                o_decoded[g] = 1'b0;
            end else if (w_is_one) begin
                o_decoded[g] = 1'b1;
            end else begin
                o_decoded[g] = i_decoded[g];
            end
        end
    end

endmodule

@@ hdl/irpcd_checker.sv @@
// port-level checks of the ir pulse command decoder and their binding
`include "ir_pulse_command_decoder_defines.svh"

module irpcd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_command_byte,
    input logic [7:0] o_edges_counted
);

    // a stalled result beat stays offered
    `IRPCD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid, "result beat dropped while stalled")

    // a stalled result beat keeps its payload
    `IRPCD_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall,
        $stable(o_command_byte) && $stable(o_edges_counted),
        "result payload changed while stalled")

    // the tick side only backs up behind a stalled result
    `IRPCD_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, o_in_stall,
        o_out_valid && i_out_stall, "tick stall without a held result")

    // no result beat right after reset
    `IRPCD_ASSERT_NOW(a_reset_quiet, i_clk, i_rst_n, $past(!i_rst_n),
        !o_out_valid, "result offered just after reset")

endmodule

bind ir_pulse_command_decoder irpcd_checker u_irpcd_checker (.*);
